[hw/rtl/clml_pkg.sv]
// shared types and codes for the cursor linked list manager
`default_nettype none
package clml_pkg;

    // fixed widths of the channel fields
    localparam int KIND_W   = 4;
    localparam int FIELD_W  = 32;
    localparam int HANDLE_W = 8;
    localparam int LEN_W    = 9;
    localparam int STATUS_W = 2;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        K_INS_AFTER  = 4'd0,
        K_INS_BEFORE = 4'd1,
        K_DEL_CUR    = 4'd2,
        K_DEL_NODE   = 4'd3,
        K_SEEK       = 4'd4,
        K_PREV       = 4'd5,
        K_NEXT       = 4'd6,
        K_HEAD       = 4'd7,
        K_TAIL       = 4'd8,
        K_CLEAR      = 4'd9
    } t_kind;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NO_MOVE    = 2'd2,
        ST_BAD_HANDLE = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_WR1  = 6'b000100,
        S_WR2  = 6'b001000,
        S_VIEW = 6'b010000,
        S_LOAD = 6'b100000
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic take;
        logic rd;
        logic wr1;
        logic wr2;
        logic view;
        logic load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
        logic out_valid;
    } t_sts;

endpackage
`default_nettype wire

[hw/rtl/clml_if.sv]
// operation and result channel interfaces
`default_nettype none
interface clml_in_if;
    import clml_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [FIELD_W-1:0]  entry_key;
    logic [FIELD_W-1:0]  entry_payload;
    logic [HANDLE_W-1:0] target_handle;
    modport source (output valid, kind, entry_key, entry_payload, target_handle,
                    input ready);
    modport sink (input valid, kind, entry_key, entry_payload, target_handle,
                  output ready);
endinterface

interface clml_out_if;
    import clml_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                cursor_present;
    logic [HANDLE_W-1:0] cursor_handle;
    logic [FIELD_W-1:0]  cursor_key;
    logic [FIELD_W-1:0]  cursor_payload;
    logic [LEN_W-1:0]    list_length;
    modport source (output valid, status, cursor_present, cursor_handle, cursor_key,
                    cursor_payload, list_length, input ready);
    modport sink (input valid, status, cursor_present, cursor_handle, cursor_key,
                  cursor_payload, list_length, output ready);
endinterface
`default_nettype wire

[hw/rtl/clml_ctrl.sv]
// sequencer that steps one operation through read, write, view and load cycles
`default_nettype none
module clml_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  clml_pkg::t_sts     i_sts,
    output clml_pkg::t_cmd     o_cmd
);
    import clml_pkg::*;

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_RD;
            S_RD:   n_state = S_WR1;
            S_WR1:  n_state = S_WR2;
            S_WR2:  n_state = S_VIEW;
            S_VIEW: n_state = S_LOAD;
            S_LOAD: if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands
    assign o_ready    = (r_state == S_IDLE);
    assign o_cmd.take = (r_state == S_IDLE) && i_valid;
    assign o_cmd.rd   = (r_state == S_RD);
    assign o_cmd.wr1  = (r_state == S_WR1);
    assign o_cmd.wr2  = (r_state == S_WR2);
    assign o_cmd.view = (r_state == S_VIEW);
    assign o_cmd.load = (r_state == S_LOAD) && i_sts.out_free;

endmodule
`default_nettype wire

[hw/rtl/clml_dp.sv]
// list datapath: link, key, payload and free stack memories, list registers
`default_nettype none
module clml_dp #(
    parameter int CAPACITY     = 256,
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  clml_pkg::t_cmd                i_cmd,
    output clml_pkg::t_sts                o_sts,
    input  wire logic [clml_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [clml_pkg::FIELD_W-1:0]  i_key,
    input  wire logic [clml_pkg::FIELD_W-1:0]  i_payload,
    input  wire logic [clml_pkg::HANDLE_W-1:0] i_target,
    input  wire logic                     i_out_ready,
    output logic [clml_pkg::STATUS_W-1:0] o_status,
    output logic                          o_present,
    output logic [clml_pkg::HANDLE_W-1:0] o_handle,
    output logic [clml_pkg::FIELD_W-1:0]  o_key,
    output logic [clml_pkg::FIELD_W-1:0]  o_payload,
    output logic [clml_pkg::LEN_W-1:0]    o_length
);
    import clml_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = AW + 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] NIL   = LW'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // deferred second link write
    typedef struct packed {
        logic          nx_en;
        logic [AW-1:0] nx_a;
        logic          pv_en;
        logic [AW-1:0] pv_a;
        logic [LW-1:0] val;
    } t_w2;

    // memories
    logic [LW-1:0]           r_prev_mem [CAPACITY];
    logic [LW-1:0]           r_next_mem [CAPACITY];
    logic [KEY_BITS-1:0]     r_key_mem  [CAPACITY];
    logic [PAYLOAD_BITS-1:0] r_pay_mem  [CAPACITY];
    logic [AW-1:0]           r_stk_mem  [CAPACITY];

    logic [LW-1:0]           r_prev_rd, r_next_rd;
    logic [AW-1:0]           r_stk_rd;
    logic [KEY_BITS-1:0]     r_key_rd;
    logic [PAYLOAD_BITS-1:0] r_pay_rd;

    // latched operation
    t_kind                   r_kind;
    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [HANDLE_W-1:0]     r_tgt;

    // list state
    logic [LW-1:0]       r_cur, r_head, r_tail, n_cur, n_head, n_tail;
    logic [CW-1:0]       r_cnt, r_rcnt, r_fresh, n_cnt, n_rcnt, n_fresh;
    logic [CAPACITY-1:0] r_live, n_live;
    t_status             r_status, n_status;
    t_w2                 r_w2, n_w2;

    // output word
    logic                r_ovalid;
    logic [STATUS_W-1:0] r_o_status;
    logic                r_o_present;
    logic [HANDLE_W-1:0] r_o_handle;
    logic [FIELD_W-1:0]  r_o_key, r_o_pay;
    logic [LEN_W-1:0]    r_o_len;

    // memory port controls
    logic          pw_en, nw_en, kw_en, sw_en;
    logic [AW-1:0] pw_a, nw_a, kw_a, sw_a;
    logic [LW-1:0] pw_d, nw_d;
    logic [AW-1:0] sw_d;

    logic [LW-1:0] c_lnk, alloc;
    logic          cur_v, tgt_ok, full;

    // node under work and allocation choice
    assign c_lnk  = (r_kind == K_DEL_NODE) ? LW'(r_tgt) : r_cur;
    assign cur_v  = (r_cur < NIL);
    assign tgt_ok = (32'(r_tgt) < 32'(CAPACITY)) && r_live[AW'(r_tgt)];
    assign alloc  = (r_rcnt != '0) ? LW'(r_stk_rd) :
                    (r_fresh < CAP_C) ? LW'(r_fresh) : NIL;
    assign full   = (alloc == NIL);

    // operation decode for the write cycles
    always_comb begin
        n_cur = r_cur; n_head = r_head; n_tail = r_tail;
        n_cnt = r_cnt; n_rcnt = r_rcnt; n_fresh = r_fresh;
        n_live = r_live; n_status = ST_OK; n_w2 = '0;
        pw_en = 1'b0; pw_a = '0; pw_d = '0;
        nw_en = 1'b0; nw_a = '0; nw_d = '0;
        kw_en = 1'b0; kw_a = '0;
        sw_en = 1'b0; sw_a = '0; sw_d = '0;
        if (i_cmd.wr1) begin
            case (r_kind)
                K_INS_AFTER, K_INS_BEFORE: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_live[AW'(alloc)] = 1'b1;
                        kw_en = 1'b1;
                        kw_a  = AW'(alloc);
                        if (r_rcnt != '0) n_rcnt = r_rcnt - CW'(1);
                        else n_fresh = r_fresh + CW'(1);
                        n_cnt = r_cnt + CW'(1);
                        n_cur = alloc;
                        pw_en = 1'b1; pw_a = AW'(alloc);
                        nw_en = 1'b1; nw_a = AW'(alloc);
                        n_w2.val = alloc;
                        if (!cur_v) begin
                            pw_d = NIL; nw_d = NIL;
                            n_head = alloc; n_tail = alloc;
                        end else if (r_kind == K_INS_AFTER) begin
                            pw_d = r_cur; nw_d = r_next_rd;
                            n_w2.nx_en = 1'b1; n_w2.nx_a = AW'(r_cur);
                            n_w2.pv_en = (r_next_rd < NIL); n_w2.pv_a = AW'(r_next_rd);
                            if (r_cur == r_tail) n_tail = alloc;
                        end else begin
                            nw_d = r_cur; pw_d = r_prev_rd;
                            n_w2.pv_en = 1'b1; n_w2.pv_a = AW'(r_cur);
                            n_w2.nx_en = (r_prev_rd < NIL); n_w2.nx_a = AW'(r_prev_rd);
                            if (r_cur == r_head) n_head = alloc;
                        end
                    end
                end
                K_DEL_CUR, K_DEL_NODE: begin
                    if (r_kind == K_DEL_CUR && !cur_v) begin
                        n_status = ST_NO_MOVE;
                    end else if (r_kind == K_DEL_NODE && !tgt_ok) begin
                        n_status = ST_BAD_HANDLE;
                    end else begin
                        n_cnt = r_cnt - CW'(1);
                        if (r_cnt == CW'(1)) begin
                            n_head = NIL; n_tail = NIL; n_cur = NIL;
                        end else begin
                            if (r_prev_rd < NIL) begin
                                nw_en = 1'b1; nw_a = AW'(r_prev_rd); nw_d = r_next_rd;
                            end
                            if (r_next_rd < NIL) begin
                                pw_en = 1'b1; pw_a = AW'(r_next_rd); pw_d = r_prev_rd;
                                n_cur = r_next_rd;
                            end else begin
                                n_cur = r_prev_rd;
                            end
                            if (c_lnk == r_head) n_head = r_next_rd;
                            if (c_lnk == r_tail) n_tail = r_prev_rd;
                        end
                        n_live[AW'(c_lnk)] = 1'b0;
                        if (r_rcnt < CAP_C) begin
                            sw_en = 1'b1; sw_a = AW'(r_rcnt); sw_d = AW'(c_lnk);
                            n_rcnt = r_rcnt + CW'(1);
                        end
                    end
                end
                K_SEEK: begin
                    if (tgt_ok) n_cur = LW'(r_tgt);
                    else n_status = ST_BAD_HANDLE;
                end
                K_PREV: begin
                    if (cur_v && r_prev_rd < NIL) n_cur = r_prev_rd;
                    else n_status = ST_NO_MOVE;
                end
                K_NEXT: begin
                    if (cur_v && r_next_rd < NIL) n_cur = r_next_rd;
                    else n_status = ST_NO_MOVE;
                end
                K_HEAD: begin
                    n_cur = r_head;
                    if (!(r_head < NIL)) n_status = ST_NO_MOVE;
                end
                K_TAIL: begin
                    n_cur = r_tail;
                    if (!(r_tail < NIL)) n_status = ST_NO_MOVE;
                end
                K_CLEAR: begin
                    n_live = '0; n_rcnt = '0; n_fresh = '0; n_cnt = '0;
                    n_cur = NIL; n_head = NIL; n_tail = NIL;
                end
                default: n_status = ST_OK;
            endcase
        end else if (i_cmd.wr2) begin
            pw_en = r_w2.pv_en; pw_a = r_w2.pv_a; pw_d = r_w2.val;
            nw_en = r_w2.nx_en; nw_a = r_w2.nx_a; nw_d = r_w2.val;
        end
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_prev_rd <= r_prev_mem[AW'(c_lnk)];
            r_next_rd <= r_next_mem[AW'(c_lnk)];
            r_stk_rd  <= r_stk_mem[AW'(r_rcnt - CW'(1))];
        end
        if (i_cmd.view) begin
            r_key_rd <= r_key_mem[AW'(r_cur)];
            r_pay_rd <= r_pay_mem[AW'(r_cur)];
        end
        if (pw_en) r_prev_mem[pw_a] <= pw_d;
        if (nw_en) r_next_mem[nw_a] <= nw_d;
        if (kw_en) begin
            r_key_mem[kw_a] <= r_key;
            r_pay_mem[kw_a] <= r_pay;
        end
        if (sw_en) r_stk_mem[sw_a] <= sw_d;
    end

    // operation latch, write-cycle payload and output word load
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_kind <= t_kind'(i_kind);
            r_key  <= KEY_BITS'(i_key);
            r_pay  <= PAYLOAD_BITS'(i_payload);
            r_tgt  <= i_target;
        end
        if (i_cmd.wr1) begin
            r_w2     <= n_w2;
            r_status <= n_status;
        end
        if (i_cmd.load) begin
            r_o_status  <= r_status;
            r_o_present <= cur_v;
            r_o_handle  <= cur_v ? HANDLE_W'(r_cur) : '0;
            r_o_key     <= cur_v ? FIELD_W'(r_key_rd) : '0;
            r_o_pay     <= cur_v ? FIELD_W'(r_pay_rd) : '0;
            r_o_len     <= LEN_W'(r_cnt);
        end
    end

    // list registers and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= NIL;
            r_head   <= NIL;
            r_tail   <= NIL;
            r_cnt    <= '0;
            r_rcnt   <= '0;
            r_fresh  <= '0;
            r_live   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.wr1) begin
                r_cur   <= n_cur;
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_cnt   <= n_cnt;
                r_rcnt  <= n_rcnt;
                r_fresh <= n_fresh;
                r_live  <= n_live;
            end
            if (i_cmd.load) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    assign o_sts.out_free  = !r_ovalid || i_out_ready;
    assign o_sts.out_valid = r_ovalid;
    assign o_status  = r_o_status;
    assign o_present = r_o_present;
    assign o_handle  = r_o_handle;
    assign o_key     = r_o_key;
    assign o_payload = r_o_pay;
    assign o_length  = r_o_len;

endmodule
`default_nettype wire

[hw/rtl/cursor_linked_list_manager_unit.sv]
// top level of the cursor linked list manager
//
//  channel  dir  modport  word
//  i_op     in   sink     kind, entry_key, entry_payload, target_handle
//  o_res    out  source   status, cursor view, list_length
//
// each operation runs from acceptance to a valid result through a link read, a
// first and second link write, a key/payload read and an output load that waits
// for a free output register; each link memory's single write port splits the
// link writes. one operation is in work at a time; a new word waits for idle.
// reset empties the list at once; node memories need no clearing.
// a result waits in the output register while the next word is accepted.
`default_nettype none
module cursor_linked_list_manager_unit #(
    parameter int CAPACITY     = 256,
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    clml_in_if.sink    i_op,
    clml_out_if.source o_res
);
    import clml_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    clml_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_op.valid),
        .o_ready (i_op.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath
    clml_dp #(
        .CAPACITY     (CAPACITY),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (i_op.kind),
        .i_key       (i_op.entry_key),
        .i_payload   (i_op.entry_payload),
        .i_target    (i_op.target_handle),
        .i_out_ready (o_res.ready),
        .o_status    (o_res.status),
        .o_present   (o_res.cursor_present),
        .o_handle    (o_res.cursor_handle),
        .o_key       (o_res.cursor_key),
        .o_payload   (o_res.cursor_payload),
        .o_length    (o_res.list_length)
    );

    assign o_res.valid = sts.out_valid;

endmodule
`default_nettype wire

[hw/rtl/clml_check.sv]
// port checker for the cursor linked list manager and its bind
`default_nettype none
module clml_check #(
    parameter int CAPACITY = 256
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [clml_pkg::STATUS_W-1:0] i_status,
    input wire logic                          i_present,
    input wire logic [clml_pkg::HANDLE_W-1:0] i_handle,
    input wire logic [clml_pkg::FIELD_W-1:0]  i_key,
    input wire logic [clml_pkg::FIELD_W-1:0]  i_payload,
    input wire logic [clml_pkg::LEN_W-1:0]    i_length
);
    import clml_pkg::*;

    // one operation at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("word accepted while operation in work");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped under stall");

    // absent cursor shows zero view
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_present |-> i_handle == '0 && i_key == '0 && i_payload == '0)
        else $error("absent cursor with nonzero view");

    // empty list has no cursor
    a_empty_nocur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_length == '0 |-> !i_present)
        else $error("cursor present on empty list");

    // full pool only when every node is in the list
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_FULL |-> i_length == LEN_W'(CAPACITY))
        else $error("pool full reported below capacity");

endmodule

bind cursor_linked_list_manager_unit clml_check #(.CAPACITY(CAPACITY)) u_clml_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_op.valid),
    .i_in_ready  (i_op.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_present   (o_res.cursor_present),
    .i_handle    (o_res.cursor_handle),
    .i_key       (o_res.cursor_key),
    .i_payload   (o_res.cursor_payload),
    .i_length    (o_res.list_length)
);
`default_nettype wire
